// ----- hw/rtl/quaternion_pose_to_ned_euler_defines.svh -----
// ---------------------------------------------------------------------------
// Pose converter assertion macros
// Shared concurrent assertion macros, clocked on clk and gated by rst_n.
// ---------------------------------------------------------------------------
`ifndef QUATERNION_POSE_TO_NED_EULER_DEFINES_SVH
`define QUATERNION_POSE_TO_NED_EULER_DEFINES_SVH
`ifndef SYNTHESIS
// General property check.
`define QPNE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Same-cycle implication check.
`define QPNE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define QPNE_ASSERT(lbl, prop, msg)
`define QPNE_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/qpne_pkg.sv -----
// ---------------------------------------------------------------------------
// Pose converter package
// Payload types, internal word widths and the CORDIC arctangent table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package qpne_pkg;

  // Term width after the shift to Q4.27.
  localparam int TERM_W = 31;
  // Sum of two squared terms.
  localparam int SQ_W = 60;
  // Root width and number of root digit steps.
  localparam int ROOT_W = 30;
  localparam int ROOT_STEPS = 30;
  // CORDIC vector and angle word width.
  localparam int CW = 34;

  // Angle of pi in accumulator units (2^31).
  localparam logic signed [CW-1:0] Z_PI = 34'sh0_8000_0000;

  // atan(2^-i) in units where 2^31 equals pi.
  localparam logic [31:0] ATAN_TBL [0:23] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;
  } in_payload_t;

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic signed [31:0] pos_north;
    logic signed [31:0] pos_east;
    logic signed [31:0] pos_down;
  } out_payload_t;

  typedef struct packed {
    logic signed [31:0] pos_north;
    logic signed [31:0] pos_east;
    logic signed [31:0] pos_down;
  } pos_t;

  // Rotation matrix terms used by the three arctangents, plus position.
  typedef struct packed {
    logic signed [TERM_W-1:0] r_num;
    logic signed [TERM_W-1:0] r_den;
    logic signed [TERM_W-1:0] p_num;
    logic signed [TERM_W-1:0] y_num;
    logic signed [TERM_W-1:0] y_den;
    pos_t                     pos;
  } terms_t;

  // One CORDIC vector with its angle accumulator.
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 zero;
  } cordic_vec_t;

endpackage

// ----- hw/rtl/quaternion_pose_to_ned_euler.sv -----
// ---------------------------------------------------------------------------
// Quaternion pose to NED Euler converter
// Turns a Q1.15 quaternion and Q16.16 ENU translation into NED roll, pitch,
// yaw binary angles and NED position.
// ---------------------------------------------------------------------------
// The block takes one pose per clock while the output is not stalled and
// returns one result per pose, in order. The pipeline holds
// 36 + CORDIC_STAGES registers: four of matrix arithmetic, thirty cells of
// the pitch denominator square root (one root bit per cell), one
// quadrant-fold register, one register per CORDIC cell, and the output
// register. The first of them loads at the transfer edge. The whole
// pipeline advances together whenever the output register is empty or
// being taken, so a stalled output freezes every stage and in_ready drops.
// in_ready is also low while rst_n is asserted.
`timescale 1ns / 1ps
`include "quaternion_pose_to_ned_euler_defines.svh"
module quaternion_pose_to_ned_euler #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  qpne_pkg::in_payload_t  in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output qpne_pkg::out_payload_t out_data
);
  import qpne_pkg::*;

  localparam int MAT_LAT = 4;
  localparam int LAT     = MAT_LAT + ROOT_STEPS + 1 + CORDIC_STAGES;
  localparam int POS_DLY = 1 + CORDIC_STAGES;

  logic                   adv;
  logic [LAT-1:0]         vld_r, vld_nxt;
  logic                   out_valid_r;
  out_payload_t           out_data_r, out_data_nxt;
  terms_t                 m_terms;
  logic [SQ_W-1:0]        m_sq_sum;
  logic [SQ_W-1:0]        v_ch   [0:ROOT_STEPS];
  logic [SQ_W-1:0]        res_ch [0:ROOT_STEPS];
  terms_t                 side_ch [0:ROOT_STEPS];
  terms_t                 side_last;
  pos_t                   pos_dly_r [0:POS_DLY-1];
  logic signed [CW-1:0]   roll_y, roll_x, pitch_y, pitch_x, yaw_y, yaw_x;
  logic signed [15:0]     roll_ang, pitch_ang, yaw_ang;

  // Global advance: the output register is free or being taken.
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv && rst_n;

  // Valid bit per stage.
  assign vld_nxt = {vld_r[LAT-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= vld_nxt;
      out_valid_r <= vld_r[LAT-1];
    end
  end

  // Matrix terms and square sum.
  qpne_matrix u_matrix (
    .clk    (clk),
    .en     (adv),
    .in_data(in_data),
    .terms  (m_terms),
    .sq_sum (m_sq_sum)
  );

  // Square root row for the pitch denominator.
  assign v_ch[0]    = m_sq_sum;
  assign res_ch[0]  = '0;
  assign side_ch[0] = m_terms;

  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
    qpne_sqrt_cell #(.STEP(k)) u_root (
      .clk     (clk),
      .en      (adv),
      .v_in    (v_ch[k]),
      .res_in  (res_ch[k]),
      .side_in (side_ch[k]),
      .v_out   (v_ch[k+1]),
      .res_out (res_ch[k+1]),
      .side_out(side_ch[k+1])
    );
  end

  assign side_last = side_ch[ROOT_STEPS];

  // Sign-extend the terms into CORDIC vectors.
  always_comb begin
    roll_y  = {{(CW-TERM_W){side_last.r_num[TERM_W-1]}}, side_last.r_num};
    roll_x  = {{(CW-TERM_W){side_last.r_den[TERM_W-1]}}, side_last.r_den};
    pitch_y = {{(CW-TERM_W){side_last.p_num[TERM_W-1]}}, side_last.p_num};
    pitch_x = {{(CW-ROOT_W){1'b0}}, res_ch[ROOT_STEPS][ROOT_W-1:0]};
    yaw_y   = {{(CW-TERM_W){side_last.y_num[TERM_W-1]}}, side_last.y_num};
    yaw_x   = {{(CW-TERM_W){side_last.y_den[TERM_W-1]}}, side_last.y_den};
  end

  qpne_cordic_lane #(.STAGES(CORDIC_STAGES)) u_roll (
    .clk(clk), .en(adv), .y_in(roll_y), .x_in(roll_x), .angle(roll_ang)
  );

  qpne_cordic_lane #(.STAGES(CORDIC_STAGES)) u_pitch (
    .clk(clk), .en(adv), .y_in(pitch_y), .x_in(pitch_x), .angle(pitch_ang)
  );

  qpne_cordic_lane #(.STAGES(CORDIC_STAGES)) u_yaw (
    .clk(clk), .en(adv), .y_in(yaw_y), .x_in(yaw_x), .angle(yaw_ang)
  );

  // Position delay line matching the CORDIC lanes.
  always_ff @(posedge clk) begin
    if (adv) begin
      pos_dly_r[0] <= side_last.pos;
      for (int i = 1; i < POS_DLY; i++) begin
        pos_dly_r[i] <= pos_dly_r[i-1];
      end
    end
  end

  // Output register.
  always_comb begin
    out_data_nxt.roll_angle  = roll_ang;
    out_data_nxt.pitch_angle = pitch_ang;
    out_data_nxt.yaw_angle   = yaw_ang;
    out_data_nxt.pos_north   = pos_dly_r[POS_DLY-1].pos_north;
    out_data_nxt.pos_east    = pos_dly_r[POS_DLY-1].pos_east;
    out_data_nxt.pos_down    = pos_dly_r[POS_DLY-1].pos_down;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A result appears only when the pipeline tail held a valid item.
  `QPNE_ASSERT(a_out_from_tail, $rose(out_valid_r) |-> $past(vld_r[LAT-1]), "output without tail item")
  // An input transfer lands in the first stage.
  `QPNE_ASSERT(a_entry, (in_valid && in_ready) |=> vld_r[0], "input transfer lost at entry")
  // A stalled pipeline keeps every valid bit.
  `QPNE_ASSERT(a_freeze, !adv |=> $stable(vld_r), "pipeline moved during stall")
  // Down position never carries the most negative value.
  `QPNE_ASSERT_IMPL(a_down_sat, out_valid_r, out_data_r.pos_down != 32'sh8000_0000, "down not saturated")

endmodule

// ----- hw/rtl/qpne_matrix.sv -----
// ---------------------------------------------------------------------------
// Pose converter matrix front end
// Four stages: quaternion products, NED matrix terms, squares, square sum.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module qpne_matrix (
  input  logic                              clk,
  input  logic                              en,
  input  qpne_pkg::in_payload_t             in_data,
  output qpne_pkg::terms_t                  terms,
  output logic [qpne_pkg::SQ_W-1:0]         sq_sum
);
  import qpne_pkg::*;

  localparam logic signed [34:0] ONE_Q30 = 35'sd1073741824;

  // Stage 1 registers.
  logic signed [31:0] p_yz_r, p_wx_r, p_xx_r, p_yy_r, p_xz_r, p_wy_r, p_zz_r, p_xy_r, p_wz_r;
  logic signed [31:0] p_yz_nxt, p_wx_nxt, p_xx_nxt, p_yy_nxt, p_xz_nxt;
  logic signed [31:0] p_wy_nxt, p_zz_nxt, p_xy_nxt, p_wz_nxt;
  pos_t pos1_r, pos1_nxt;
  // Stage 2 to 4 registers.
  terms_t terms2_r, terms2_nxt, terms3_r, terms4_r;
  logic signed [34:0] s_rn, s_rd, s_pn, s_yn, s_yd;
  logic signed [34:0] q_rn, q_rd, q_pn, q_yn, q_yd;
  logic signed [61:0] rn_sq_full, rd_sq_full;
  logic [SQ_W-1:0] rn_sq_r, rd_sq_r, sq_sum_r, sq_sum_nxt;

  // Products of quaternion parts, exact in Q2.30, and the frame swap.
  always_comb begin
    p_yz_nxt = in_data.quat_y * in_data.quat_z;
    p_wx_nxt = in_data.quat_w * in_data.quat_x;
    p_xx_nxt = in_data.quat_x * in_data.quat_x;
    p_yy_nxt = in_data.quat_y * in_data.quat_y;
    p_xz_nxt = in_data.quat_x * in_data.quat_z;
    p_wy_nxt = in_data.quat_w * in_data.quat_y;
    p_zz_nxt = in_data.quat_z * in_data.quat_z;
    p_xy_nxt = in_data.quat_x * in_data.quat_y;
    p_wz_nxt = in_data.quat_w * in_data.quat_z;
    pos1_nxt.pos_north = in_data.trans_y;
    pos1_nxt.pos_east  = in_data.trans_x;
    // Negating the most negative value saturates to the largest positive.
    if (in_data.trans_z == 32'sh8000_0000) begin
      pos1_nxt.pos_down = 32'sh7FFF_FFFF;
    end else begin
      pos1_nxt.pos_down = -in_data.trans_z;
    end
  end

  // Matrix terms: twice the product sums (or one minus that), floor-shifted right by two or three to Q4.27.
  always_comb begin
    s_rn = 35'(p_yz_r) + 35'(p_wx_r);
    s_rd = ONE_Q30 - ((35'(p_xx_r) + 35'(p_yy_r)) <<< 1);
    s_pn = 35'(p_xz_r) - 35'(p_wy_r);
    s_yn = ONE_Q30 - ((35'(p_yy_r) + 35'(p_zz_r)) <<< 1);
    s_yd = 35'(p_xy_r) + 35'(p_wz_r);
    q_rn = s_rn >>> 2;
    q_rd = s_rd >>> 3;
    q_pn = s_pn >>> 2;
    q_yn = s_yn >>> 3;
    q_yd = s_yd >>> 2;
    terms2_nxt.r_num = q_rn[TERM_W-1:0];
    terms2_nxt.r_den = q_rd[TERM_W-1:0];
    terms2_nxt.p_num = q_pn[TERM_W-1:0];
    terms2_nxt.y_num = q_yn[TERM_W-1:0];
    terms2_nxt.y_den = q_yd[TERM_W-1:0];
    terms2_nxt.pos   = pos1_r;
  end

  // Squares of the roll terms and their sum for the pitch denominator.
  always_comb begin
    rn_sq_full = terms2_r.r_num * terms2_r.r_num;
    rd_sq_full = terms2_r.r_den * terms2_r.r_den;
    sq_sum_nxt = rn_sq_r + rd_sq_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_yz_r   <= p_yz_nxt;
      p_wx_r   <= p_wx_nxt;
      p_xx_r   <= p_xx_nxt;
      p_yy_r   <= p_yy_nxt;
      p_xz_r   <= p_xz_nxt;
      p_wy_r   <= p_wy_nxt;
      p_zz_r   <= p_zz_nxt;
      p_xy_r   <= p_xy_nxt;
      p_wz_r   <= p_wz_nxt;
      pos1_r   <= pos1_nxt;
      terms2_r <= terms2_nxt;
      rn_sq_r  <= rn_sq_full[SQ_W-1:0];
      rd_sq_r  <= rd_sq_full[SQ_W-1:0];
      terms3_r <= terms2_r;
      sq_sum_r <= sq_sum_nxt;
      terms4_r <= terms3_r;
    end
  end

  assign terms  = terms4_r;
  assign sq_sum = sq_sum_r;

endmodule

// ----- hw/rtl/qpne_sqrt_cell.sv -----
// ---------------------------------------------------------------------------
// Pose converter square root cell
// One digit step of the integer square root, with side data carried along.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module qpne_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [qpne_pkg::SQ_W-1:0]  v_in,
  input  logic [qpne_pkg::SQ_W-1:0]  res_in,
  input  qpne_pkg::terms_t           side_in,
  output logic [qpne_pkg::SQ_W-1:0]  v_out,
  output logic [qpne_pkg::SQ_W-1:0]  res_out,
  output qpne_pkg::terms_t           side_out
);
  import qpne_pkg::*;

  // Trial bit for this step: a power of four walking down from 2^58.
  localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * STEP);

  logic [SQ_W:0]   trial;
  logic [SQ_W-1:0] v_r, v_nxt, res_r, res_nxt;
  terms_t          side_r;

  // Subtract the trial value when it fits and set this root digit.
  always_comb begin
    trial = {1'b0, res_in} + {1'b0, BIT};
    if ({1'b0, v_in} >= trial) begin
      v_nxt   = v_in - trial[SQ_W-1:0];
      res_nxt = (res_in >> 1) + BIT;
    end else begin
      v_nxt   = v_in;
      res_nxt = res_in >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r    <= v_nxt;
      res_r  <= res_nxt;
      side_r <= side_in;
    end
  end

  assign v_out    = v_r;
  assign res_out  = res_r;
  assign side_out = side_r;

endmodule

// ----- hw/rtl/qpne_cordic_cell.sv -----
// ---------------------------------------------------------------------------
// Pose converter CORDIC cell
// One vectoring micro-rotation by atan(2^-IDX), registered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module qpne_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic                    clk,
  input  logic                    en,
  input  qpne_pkg::cordic_vec_t   vec_in,
  output qpne_pkg::cordic_vec_t   vec_out
);
  import qpne_pkg::*;

  localparam logic signed [CW-1:0] ANG = $signed({2'b00, ATAN_TBL[IDX]});

  logic signed [CW-1:0] x_i, y_i, xs, ys;
  cordic_vec_t vec_r, vec_nxt;

  // Turn toward the x axis; the sign of y picks the direction.
  always_comb begin
    x_i = vec_in.x;
    y_i = vec_in.y;
    xs  = x_i >>> IDX;
    ys  = y_i >>> IDX;
    vec_nxt.zero = vec_in.zero;
    if (!y_i[CW-1]) begin
      vec_nxt.x = x_i + ys;
      vec_nxt.y = y_i - xs;
      vec_nxt.z = vec_in.z + ANG;
    end else begin
      vec_nxt.x = x_i - ys;
      vec_nxt.y = y_i + xs;
      vec_nxt.z = vec_in.z - ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_r <= vec_nxt;
    end
  end

  assign vec_out = vec_r;

endmodule

// ----- hw/rtl/qpne_cordic_lane.sv -----
// ---------------------------------------------------------------------------
// Pose converter CORDIC lane
// Quadrant fold followed by a row of micro-rotation cells; gives atan2(y, x).
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module qpne_cordic_lane #(
  parameter int STAGES = 16
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [qpne_pkg::CW-1:0] y_in,
  input  logic signed [qpne_pkg::CW-1:0] x_in,
  output logic signed [15:0]            angle
);
  import qpne_pkg::*;

  localparam logic signed [CW-1:0] HALF_LSB = 34'sd32768;

  cordic_vec_t          pre_r, pre_nxt;
  cordic_vec_t          chain [0:STAGES];
  logic signed [CW-1:0] z_rnd;

  // Fold the left half plane onto the right half, starting at plus or minus pi.
  always_comb begin
    pre_nxt.zero = (x_in == '0) && (y_in == '0);
    if (x_in[CW-1]) begin
      pre_nxt.x = -x_in;
      pre_nxt.y = -y_in;
      pre_nxt.z = y_in[CW-1] ? -Z_PI : Z_PI;
    end else begin
      pre_nxt.x = x_in;
      pre_nxt.y = y_in;
      pre_nxt.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre_r <= pre_nxt;
    end
  end

  assign chain[0] = pre_r;

  for (genvar g = 0; g < STAGES; g++) begin : g_cell
    qpne_cordic_cell #(.IDX(g)) u_cell (
      .clk    (clk),
      .en     (en),
      .vec_in (chain[g]),
      .vec_out(chain[g+1])
    );
  end

  // Round to 16-bit binary angle; a zero vector gives angle zero.
  always_comb begin
    z_rnd = chain[STAGES].z + HALF_LSB;
    angle = chain[STAGES].zero ? 16'sd0 : z_rnd[31:16];
  end

endmodule
